// ===== hdl/frame_rotator_right_angle_macros.svh =====
// ----------------------------------------------------------------------------
// Frame rotator assertion macros
// Wrappers for the concurrent checks of the rotator.
// ----------------------------------------------------------------------------
`ifndef FRAME_ROTATOR_RIGHT_ANGLE_MACROS_SVH
`define FRAME_ROTATOR_RIGHT_ANGLE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define FRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FRA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame rotator package
// Sizes, register indexes and rotation codes of the right-angle rotator.
// ----------------------------------------------------------------------------
package fra_pkg;

	localparam int MAX_DIM     = 256;
	localparam int PIXEL_BITS  = 24;
	localparam int DIM_W       = 9;
	localparam int COORD_W     = 8;
	localparam int ADDR_W      = 16;
	localparam int TOT_W       = 17;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int OUT_PIX_W   = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_MODE = 2'd2;

	localparam logic [1:0] ROT_90  = 2'd0;
	localparam logic [1:0] ROT_180 = 2'd1;
	localparam logic [1:0] ROT_270 = 2'd2;

	localparam logic STATUS_VALID     = 1'b0;
	localparam logic STATUS_NOT_READY = 1'b1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

endpackage

// ===== hdl/frame_rotator_right_angle.sv =====
// ----------------------------------------------------------------------------
// Right-angle frame rotator
// Stores a raster frame at rotated addresses and streams it back rotated.
// ----------------------------------------------------------------------------
// Usage:
//   Configure frame_width, frame_height and rotation_mode through cfg_we,
//   cfg_index and cfg_data while the block is idle; writes to these restart the
//   frame. A command beat is taken when start is high and busy is low;
//   req_type selects a pixel write (raster order) or a rotated pixel read.
//   Each write lands directly at its rotated address in a 64K-word frame
//   store, the address coming from incremental counters. Writes give no
//   result; writes past a full frame are dropped.
//   Each read returns one result beat, marked by done, in the cycle after the
//   command, from the store's registered read port. A read before the frame
//   is full returns read_status set and no pixel.
//   One command per cycle is taken, back to back; busy stays low.
//   The receiver cannot stall: every result beat lasts one cycle.
//   Reset restores width 1, height 1, 90 degrees and an empty frame. The
//   store is not cleared; no clearing pass runs, so the block is ready at
//   the first cycle after reset.
// ----------------------------------------------------------------------------
`include "frame_rotator_right_angle_macros.svh"

module frame_rotator_right_angle
	import fra_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic                  req_type,
	input  logic [23:0]           pixel_in,
	output logic                  done,
	output logic [OUT_PIX_W-1:0]  pixel_out,
	output logic [DIM_W-1:0]      out_width,
	output logic [DIM_W-1:0]      out_height,
	output logic                  last_pixel,
	output logic                  read_status
);

	logic [DIM_W-1:0]      frame_width_q;
	logic [DIM_W-1:0]      frame_height_q;
	logic [1:0]            rotation_mode_q;

	logic [COORD_W-1:0]    write_col_q;
	logic [COORD_W-1:0]    write_row_q;
	logic [ADDR_W-1:0]     read_index_q;
	logic                  frame_full_q;
	logic                  first_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [ADDR_W-1:0]     row_base_q;

	logic                  done_s1;
	logic                  status_s1;
	logic                  last_s1;
	logic [DIM_W-1:0]      owidth_s1;
	logic [DIM_W-1:0]      oheight_s1;
	logic [PIXEL_BITS-1:0] rd_data_s1;

	logic [PIXEL_BITS-1:0] frame_store [STORE_DEPTH];

	logic [DIM_W-1:0]      w_eff;
	logic [DIM_W-1:0]      h_eff;
	logic [1:0]            mode_eff;
	logic [TOT_W-1:0]      total;
	logic [ADDR_W-1:0]     h_a;
	logic [ADDR_W-1:0]     start_addr;
	logic [ADDR_W-1:0]     start_base;
	logic [ADDR_W-1:0]     cur_addr;
	logic [ADDR_W-1:0]     cur_base;
	logic [ADDR_W-1:0]     addr_n;
	logic [ADDR_W-1:0]     base_n;
	logic                  col_last;
	logic                  row_last;
	logic                  read_last;
	logic                  accept;
	logic                  wr_en;
	logic                  rd_en;

	always_comb begin
		priority if (frame_width_q == '0) w_eff = DIM_W'(1);
		else if (frame_width_q > DIM_W'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
		else w_eff = frame_width_q;
		priority if (frame_height_q == '0) h_eff = DIM_W'(1);
		else if (frame_height_q > DIM_W'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
		else h_eff = frame_height_q;
		mode_eff = (rotation_mode_q == ROT_90 || rotation_mode_q == ROT_180 ||
			rotation_mode_q == ROT_270) ? rotation_mode_q : ROT_90;
	end

	assign total = TOT_W'(w_eff) * TOT_W'(h_eff);
	assign h_a   = ADDR_W'(h_eff);

	always_comb begin
		unique case (mode_eff)
			ROT_180: begin
				start_addr = ADDR_W'(total - TOT_W'(1));
				start_base = start_addr;
			end
			ROT_270: begin
				start_addr = ADDR_W'(total - TOT_W'(h_eff));
				start_base = start_addr;
			end
			default: begin
				start_addr = h_a - ADDR_W'(1);
				start_base = start_addr;
			end
		endcase
	end

	assign cur_addr = first_q ? start_addr : addr_q;
	assign cur_base = first_q ? start_base : row_base_q;
	assign col_last = (DIM_W'(write_col_q) + DIM_W'(1)) >= w_eff;
	assign row_last = (DIM_W'(write_row_q) + DIM_W'(1)) >= h_eff;
	assign read_last = (TOT_W'(read_index_q) + TOT_W'(1)) >= total;

	// advance the rotated write address
	always_comb begin
		base_n = cur_base;
		unique case (mode_eff)
			ROT_180: begin
				addr_n = cur_addr - ADDR_W'(1);
			end
			ROT_270: begin
				if (col_last) begin
					base_n = cur_base + ADDR_W'(1);
					addr_n = base_n;
				end else begin
					addr_n = cur_addr - h_a;
				end
			end
			default: begin
				if (col_last) begin
					base_n = cur_base - ADDR_W'(1);
					addr_n = base_n;
				end else begin
					addr_n = cur_addr + h_a;
				end
			end
		endcase
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign wr_en  = accept && (req_type == REQ_WRITE) && !frame_full_q;
	assign rd_en  = accept && (req_type == REQ_READ) && frame_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= DIM_W'(1);
			frame_height_q  <= DIM_W'(1);
			rotation_mode_q <= ROT_90;
			write_col_q     <= '0;
			write_row_q     <= '0;
			read_index_q    <= '0;
			frame_full_q    <= 1'b0;
			first_q         <= 1'b1;
			addr_q          <= '0;
			row_base_q      <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
				cfg_index == CFG_ROTATION_MODE) begin
				unique case (cfg_index)
					CFG_FRAME_WIDTH:  frame_width_q   <= cfg_data;
					CFG_FRAME_HEIGHT: frame_height_q  <= cfg_data;
					default:          rotation_mode_q <= cfg_data[1:0];
				endcase
				write_col_q  <= '0;
				write_row_q  <= '0;
				read_index_q <= '0;
				frame_full_q <= 1'b0;
				first_q      <= 1'b1;
			end
		end else if (wr_en) begin
			first_q    <= 1'b0;
			addr_q     <= addr_n;
			row_base_q <= base_n;
			if (col_last) begin
				write_col_q <= '0;
				if (row_last) frame_full_q <= 1'b1;
				else write_row_q <= write_row_q + COORD_W'(1);
			end else begin
				write_col_q <= write_col_q + COORD_W'(1);
			end
		end else if (rd_en) begin
			if (read_last) begin
				write_col_q  <= '0;
				write_row_q  <= '0;
				read_index_q <= '0;
				frame_full_q <= 1'b0;
				first_q      <= 1'b1;
			end else begin
				read_index_q <= read_index_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) frame_store[cur_addr] <= pixel_in[PIXEL_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_s1 <= frame_store[read_index_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept && (req_type == REQ_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_READ)) begin
			status_s1  <= frame_full_q ? STATUS_VALID : STATUS_NOT_READY;
			last_s1    <= frame_full_q && read_last;
			owidth_s1  <= (mode_eff == ROT_180) ? w_eff : h_eff;
			oheight_s1 <= (mode_eff == ROT_180) ? h_eff : w_eff;
		end
	end

	assign done        = done_s1;
	assign read_status = status_s1;
	assign last_pixel  = last_s1;
	assign out_width   = owidth_s1;
	assign out_height  = oheight_s1;
	assign pixel_out   = (status_s1 == STATUS_VALID) ? rd_data_s1[OUT_PIX_W-1:0] : '0;

	`FRA_ASSERT_NEXT(a_read_gives_beat, clk, arst_n, accept && req_type == REQ_READ, done)
	`FRA_ASSERT_NEXT(a_no_spurious_beat, clk, arst_n, !(accept && req_type == REQ_READ), !done)
	`FRA_ASSERT_NOW(a_read_only_when_full, clk, arst_n, read_index_q != '0, frame_full_q)
	`FRA_ASSERT_NOW(a_col_in_frame, clk, arst_n, !cfg_we, DIM_W'(write_col_q) < w_eff)

endmodule
